@@ hdl/xcs_pkg.sv @@
// Package: shared constants and types of the XMODEM checksum sender.
`default_nettype none

package xcs_pkg;

  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned FILL_W      = $clog2(BLOCK_BYTES + 1);
  localparam int unsigned SEND_W      = $clog2(BLOCK_BYTES + 4);

  localparam logic [7:0] SYM_SOH = 8'd1;
  localparam logic [7:0] SYM_EOT = 8'd4;
  localparam logic [7:0] SYM_ACK = 8'd6;
  localparam logic [7:0] SYM_NAK = 8'd21;

  typedef enum logic [1:0] {
    OP_FILE_BYTE = 2'd0,
    OP_FILE_END  = 2'd1,
    OP_LINE_BYTE = 2'd2,
    OP_TX_PULL   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PH_WAIT_NAK = 3'd0,
    PH_LOAD     = 3'd1,
    PH_SEND     = 3'd2,
    PH_REPLY    = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
  } tx_res_t;

endpackage

`default_nettype wire

@@ hdl/xcs_ram.sv @@
// Generic single-port-write RAM with registered read.
`default_nettype none

module xcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/xmodem_checksum_sender.sv @@
// Top level: XMODEM sender with 8-bit checksum and 128-byte block buffer.
//
// Input stream (s_axis): tuser carries the operation (file byte, end of
// file, byte received from the line, transmitter pull), tdata the byte.
// Every accepted transaction yields exactly one result transaction on
// m_axis: tuser flags a byte to send, tdata carries that byte with the
// packet number, sender status and buffer-free flag, tlast marks the
// checksum byte of a frame or EOT.
// The result is registered at the edge that accepts the transaction.
// One transaction per cycle is sustained while results are taken; the block
// buffer is read one pull ahead, its address taken from the next state.
// The configuration channel writes the pad byte and is always ready.
// After reset the sender awaits the first NAK with an empty buffer and
// packet number 1; the buffer contents are not cleared.
// When the receiver stalls, the result register holds and s_axis_tready
// drops only while the held result is not taken.
`default_nettype none

module xmodem_checksum_sender
  import xcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic [1:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // tx_byte, packet_number,
                                           // sender_status, buffer_free, zero fill
  output logic             m_axis_tlast,   // frame_last
  output logic             m_axis_tuser    // tx_valid
);

  phase_e            phase_q, phase_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SEND_W-1:0] idx_q, idx_d;
  logic [7:0]        pkt_q, pkt_d;
  logic [7:0]        sum_q, sum_d;
  logic              ended_q, ended_d;
  logic [7:0]        pad_q;

  logic              out_valid_q;
  tx_res_t           res_q;
  logic [7:0]        pkt_out_q;
  logic [2:0]        status_q;
  logic              free_q;

  op_e               op;
  logic              accept;
  logic              can_accept;
  logic              settle;
  logic              wr_en;
  logic [7:0]        rd_data;
  logic [SEND_W-1:0] k_q, k_d;
  logic              free_d;
  tx_res_t           res_d;

  assign op            = op_e'(s_axis_tuser);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign can_accept = (phase_q == PH_WAIT_NAK || phase_q == PH_LOAD) && !ended_q &&
                      ({1'b0, fill_q} < (FILL_W + 1)'(BLOCK_BYTES));
  assign k_q = idx_q - SEND_W'(3);
  assign k_d = idx_d - SEND_W'(3);

  xcs_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (k_d[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // Result byte of a pull.
  always_comb begin
    res_d = '0;
    if (accept && op == OP_TX_PULL) begin
      if (phase_q == PH_SEND) begin
        res_d.tx_valid = 1'b1;
        if (idx_q == SEND_W'(0)) begin
          res_d.tx_byte = SYM_SOH;
        end else if (idx_q == SEND_W'(1)) begin
          res_d.tx_byte = pkt_q;
        end else if (idx_q == SEND_W'(2)) begin
          res_d.tx_byte = ~pkt_q;
        end else if (idx_q < SEND_W'(BLOCK_BYTES + 3)) begin
          res_d.tx_byte = (k_q < SEND_W'(fill_q)) ? rd_data : pad_q;
        end else begin
          res_d.tx_byte    = sum_q;
          res_d.frame_last = 1'b1;
        end
      end else if (phase_q == PH_LOAD && ended_q && fill_q == '0) begin
        res_d.tx_valid   = 1'b1;
        res_d.tx_byte    = SYM_EOT;
        res_d.frame_last = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    pkt_d   = pkt_q;
    sum_d   = sum_q;
    ended_d = ended_q;
    settle  = 1'b0;
    wr_en   = 1'b0;
    if (accept) begin
      case (op)
        OP_FILE_BYTE: begin
          if (can_accept) begin
            wr_en  = 1'b1;
            fill_d = fill_q + FILL_W'(1);
            settle = 1'b1;
          end
        end
        OP_FILE_END: begin
          if (phase_q != PH_DONE) begin
            ended_d = 1'b1;
            settle  = 1'b1;
          end
        end
        OP_LINE_BYTE: begin
          if (phase_q == PH_WAIT_NAK) begin
            if (s_axis_tdata == SYM_NAK) begin
              phase_d = PH_LOAD;
              settle  = 1'b1;
            end
          end else if (phase_q == PH_REPLY) begin
            if (s_axis_tdata == SYM_ACK) begin
              pkt_d   = pkt_q + 8'd1;
              fill_d  = '0;
              phase_d = PH_LOAD;
              settle  = 1'b1;
            end else if (s_axis_tdata == SYM_NAK) begin
              phase_d = PH_SEND;
              idx_d   = '0;
              sum_d   = '0;
            end
          end
        end
        OP_TX_PULL: begin
          if (phase_q == PH_SEND) begin
            if (res_d.frame_last) begin
              phase_d = PH_REPLY;
            end else begin
              idx_d = idx_q + SEND_W'(1);
              if (idx_q > SEND_W'(2)) begin
                sum_d = sum_q + res_d.tx_byte;
              end
            end
          end else if (res_d.tx_valid) begin
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      if (settle && phase_d == PH_LOAD &&
          ({1'b0, fill_d} >= (FILL_W + 1)'(BLOCK_BYTES) ||
           (ended_d && fill_d != '0))) begin
        phase_d = PH_SEND;
        idx_d   = '0;
        sum_d   = '0;
      end
    end
  end

  assign free_d = (phase_d == PH_WAIT_NAK || phase_d == PH_LOAD) && !ended_d &&
                  ({1'b0, fill_d} < (FILL_W + 1)'(BLOCK_BYTES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_NAK;
      fill_q      <= '0;
      idx_q       <= '0;
      pkt_q       <= 8'd1;
      sum_q       <= '0;
      ended_q     <= 1'b0;
      pad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      pkt_q   <= pkt_d;
      sum_q   <= sum_d;
      ended_q <= ended_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pad_q <= cfg_data_i;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q     <= res_d;
      pkt_out_q <= pkt_d;
      status_q  <= phase_d;
      free_q    <= free_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, free_q, status_q, pkt_out_q, res_q.tx_byte};
  assign m_axis_tlast  = res_q.frame_last;
  assign m_axis_tuser  = res_q.tx_valid;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for the XMODEM checksum sender: directed opening, random transfer, stream checks.
`timescale 1ns / 100ps

module tb;
  import xcs_pkg::*;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [7:0] pkt_num;
    phase_e     status;
    logic       buf_free;
  } sender_out_t;

  typedef struct {
    op_e         op;
    logic [7:0]  data;
    bit          typed;
    sender_out_t want;
  } stim_row_t;

  localparam sender_out_t IDLE_OUT = '{tx_valid: 1'b0, tx_byte: 8'h00, frame_last: 1'b0,
                                       pkt_num: 8'd1, status: PH_WAIT_NAK, buf_free: 1'b1};

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  xmodem_checksum_sender DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Sender state as predicted
  phase_e      tx_phase;
  logic [7:0]  blk_data [BLOCK_BYTES];
  int          blk_fill;
  int          frame_pos;
  logic [7:0]  pkt_no;
  logic [7:0]  blk_sum;
  bit          file_done;
  logic [7:0]  pad_val;

  sender_out_t tx_due [$];
  int          errors;
  int          items_sent;
  int          burst_left;
  int          ready_left;
  int          stall_left;

  stim_row_t opening_rows [9] = '{
    '{OP_TX_PULL,   8'h00,   1'b1, IDLE_OUT},
    '{OP_LINE_BYTE, SYM_ACK, 1'b1, IDLE_OUT},
    '{OP_LINE_BYTE, 8'h00,   1'b1, IDLE_OUT},
    '{OP_LINE_BYTE, 8'hFF,   1'b1, IDLE_OUT},
    '{OP_TX_PULL,   8'hFF,   1'b1, IDLE_OUT},
    '{OP_FILE_BYTE, 8'h00,   1'b0, IDLE_OUT},
    '{OP_FILE_BYTE, 8'hFF,   1'b0, IDLE_OUT},
    '{OP_FILE_BYTE, 8'h5A,   1'b0, IDLE_OUT},
    '{OP_LINE_BYTE, SYM_EOT, 1'b1, IDLE_OUT}
  };

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic bit room_for_byte();
    return (tx_phase == PH_WAIT_NAK || tx_phase == PH_LOAD) && !file_done &&
           blk_fill < BLOCK_BYTES;
  endfunction

  function automatic void restart_frame();
    tx_phase  = PH_SEND;
    frame_pos = 0;
    blk_sum   = 8'h00;
  endfunction

  function automatic void start_frame_if_due();
    if (tx_phase == PH_LOAD && (blk_fill >= BLOCK_BYTES || (file_done && blk_fill > 0)))
      restart_frame();
  endfunction

  function automatic sender_out_t advance_sender(op_e op, logic [7:0] b);
    sender_out_t r;
    int          k;
    r = '0;
    case (op)
      OP_FILE_BYTE: begin
        if (room_for_byte()) begin
          blk_data[blk_fill] = b;
          blk_fill++;
          start_frame_if_due();
        end
      end
      OP_FILE_END: begin
        if (tx_phase != PH_DONE) begin
          file_done = 1'b1;
          start_frame_if_due();
        end
      end
      OP_LINE_BYTE: begin
        if (tx_phase == PH_WAIT_NAK) begin
          if (b == SYM_NAK) begin
            tx_phase = PH_LOAD;
            start_frame_if_due();
          end
        end else if (tx_phase == PH_REPLY) begin
          if (b == SYM_ACK) begin
            pkt_no   = pkt_no + 8'd1;
            blk_fill = 0;
            tx_phase = PH_LOAD;
            start_frame_if_due();
          end else if (b == SYM_NAK) begin
            restart_frame();
          end
        end
      end
      default: begin
        if (tx_phase == PH_SEND) begin
          r.tx_valid = 1'b1;
          if (frame_pos == 0) begin
            r.tx_byte = SYM_SOH;
          end else if (frame_pos == 1) begin
            r.tx_byte = pkt_no;
          end else if (frame_pos == 2) begin
            r.tx_byte = ~pkt_no;
          end else if (frame_pos < BLOCK_BYTES + 3) begin
            k = frame_pos - 3;
            r.tx_byte = (k < blk_fill) ? blk_data[k] : pad_val;
            blk_sum = blk_sum + r.tx_byte;
          end else begin
            r.tx_byte    = blk_sum;
            r.frame_last = 1'b1;
            tx_phase     = PH_REPLY;
          end
          if (tx_phase == PH_SEND)
            frame_pos++;
        end else if (tx_phase == PH_LOAD && file_done && blk_fill == 0) begin
          r.tx_valid   = 1'b1;
          r.tx_byte    = SYM_EOT;
          r.frame_last = 1'b1;
          tx_phase     = PH_DONE;
        end
      end
    endcase
    r.pkt_num  = pkt_no;
    r.status   = tx_phase;
    r.buf_free = room_for_byte();
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    sender_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tx_due.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, 0);
      end else begin
        want = tx_due.pop_front();
        if (m_axis_tuser !== want.tx_valid)
          report_mismatch("tx_valid", m_axis_tuser, want.tx_valid);
        if (m_axis_tdata[7:0] !== want.tx_byte)
          report_mismatch("tx_byte", m_axis_tdata[7:0], want.tx_byte);
        if (m_axis_tlast !== want.frame_last)
          report_mismatch("frame_last", m_axis_tlast, want.frame_last);
        if (m_axis_tdata[15:8] !== want.pkt_num)
          report_mismatch("packet_number", m_axis_tdata[15:8], want.pkt_num);
        if (m_axis_tdata[18:16] !== want.status)
          report_mismatch("sender_status", m_axis_tdata[18:16], want.status);
        if (m_axis_tdata[19] !== want.buf_free)
          report_mismatch("buffer_free", m_axis_tdata[19], want.buf_free);
        if (m_axis_tdata[23:20] !== 4'h0)
          report_mismatch("tdata fill bits", m_axis_tdata[23:20], 0);
      end
    end
  end

  // Receiver stalls in runs of its own
  always @(negedge clk_i) begin
    if (ready_left > 0) begin
      m_axis_tready <= 1'b1;
      ready_left--;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      stall_left = $urandom_range(1, 5);
    end
  end

  task automatic offer_item(op_e op, logic [7:0] b, bit typed = 1'b0,
                            sender_out_t want = '0);
    sender_out_t r;
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    r = advance_sender(op, b);
    tx_due.push_back(typed ? want : r);
    items_sent++;
    burst_left--;
  endtask

  task automatic write_pad(logic [7:0] v);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tx_due.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    pad_val = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SYM_ACK || b == SYM_NAK)
      b = b ^ 8'h80;
    return b;
  endfunction

  // Insert an item the sender must ignore in its present phase (a pull after file end with an empty buffer sends EOT)
  task automatic phase_noise();
    case (tx_phase)
      PH_SEND: begin
        case ($urandom_range(0, 2))
          0: offer_item(OP_FILE_BYTE, 8'($urandom));
          1: offer_item(OP_LINE_BYTE, 8'($urandom));
          default: offer_item(OP_LINE_BYTE, $urandom_range(0, 1) ? SYM_NAK : SYM_ACK);
        endcase
      end
      PH_DONE: offer_item(op_e'($urandom_range(0, 3)), 8'($urandom));
      default: begin
        case ($urandom_range(0, 2))
          0: offer_item(OP_TX_PULL, 8'($urandom));
          1: offer_item(OP_LINE_BYTE, junk_byte());
          default: begin
            if (tx_phase == PH_REPLY)
              offer_item(OP_FILE_BYTE, 8'($urandom));
            else
              offer_item(OP_LINE_BYTE, junk_byte());
          end
        endcase
      end
    endcase
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 6) == 0)
      phase_noise();
  endtask

  task automatic load_block(int n, bit nak_due);
    int nak_at;
    nak_at = $urandom_range(0, 1) ? n : $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      maybe_noise();
      if (nak_due && i == nak_at)
        offer_item(OP_LINE_BYTE, SYM_NAK);
      offer_item(OP_FILE_BYTE, 8'($urandom));
    end
    if (nak_due && nak_at == n) begin
      offer_item(OP_FILE_BYTE, 8'($urandom));
      offer_item(OP_FILE_BYTE, 8'($urandom));
      offer_item(OP_LINE_BYTE, SYM_NAK);
    end
  endtask

  task automatic transfer_frame(bit pad_mid);
    int tries;
    bit again;
    int pad_at;
    tries = 0;
    do begin
      pad_at = $urandom_range(3, BLOCK_BYTES + 3);
      for (int i = 0; i < BLOCK_BYTES + 4; i++) begin
        maybe_noise();
        if (pad_mid && i == pad_at)
          write_pad(8'($urandom));
        offer_item(OP_TX_PULL, 8'($urandom));
      end
      maybe_noise();
      maybe_noise();
      again = (tries == 0 && $urandom_range(0, 3) == 0);
      tries++;
      offer_item(OP_LINE_BYTE, again ? SYM_NAK : SYM_ACK);
    end while (again);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = 8'h00;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = OP_FILE_BYTE;
    m_axis_tready = 1'b0;
    errors        = 0;
    items_sent    = 0;
    burst_left    = 0;
    ready_left    = 0;
    stall_left    = 0;
    tx_phase      = PH_WAIT_NAK;
    blk_fill      = 0;
    frame_pos     = 0;
    pkt_no        = 8'd1;
    blk_sum       = 8'h00;
    file_done     = 1'b0;
    pad_val       = 8'h00;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_pad(8'hFF);
    foreach (opening_rows[i])
      offer_item(opening_rows[i].op, opening_rows[i].data, opening_rows[i].typed,
                 opening_rows[i].want);

    load_block(BLOCK_BYTES - blk_fill, 1'b1);
    transfer_frame(1'b0);
    while (items_sent < 700) begin
      if ($urandom_range(0, 1) == 0)
        write_pad(8'($urandom));
      load_block(BLOCK_BYTES, 1'b0);
      transfer_frame(1'b0);
    end

    write_pad(8'h00);
    if ($urandom_range(0, 3) != 0) begin
      load_block($urandom_range(1, BLOCK_BYTES - 1), 1'b0);
      offer_item(OP_FILE_END, 8'($urandom));
      offer_item(OP_FILE_END, 8'($urandom));
      transfer_frame(1'b1);
    end else begin
      offer_item(OP_FILE_END, 8'($urandom));
      offer_item(OP_FILE_END, 8'($urandom));
      offer_item(OP_FILE_BYTE, 8'($urandom));
    end
    maybe_noise();
    offer_item(OP_TX_PULL, 8'($urandom));
    repeat (12) phase_noise();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 1000 && tx_due.size() != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tx_due.size() != 0)
      report_mismatch("results never produced", 0, tx_due.size());
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
